// ===== hw/rtl/wes_pkg.sv =====
// Shared constants, configuration codes and inter-module structs for the
// wave equation stencil update block. No dependencies.
package wes_pkg;

  localparam int MAX_DIM     = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Fixed field widths of the register map and the result word.
  localparam int SIZE_W     = 7;
  localparam int COEF_W     = 18;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam int MIN_DIM    = 3;
  localparam int RESET_DIM  = 64;

  // Grid sizes and scan indices share one width wide enough for all uses.
  localparam int SZ_W   = $clog2(MAX_DIM + 1);
  localparam int DIM_W0 = (SZ_W > POS_W) ? SZ_W : POS_W;
  localparam int DIM_W  = (DIM_W0 > SIZE_W) ? DIM_W0 : SIZE_W;

  // One plane of values fits in each delay store.
  localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int PLANE_W = $clog2(MAX_DIM * MAX_DIM + 1);

  // Arithmetic widths: second differences, weighted products and sums.
  localparam int DIFF_W = VALUE_WIDTH + 2;
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RES_W  = SUM_W + 1;
  localparam logic signed [RES_W-1:0] RES_MAX =
    {{(RES_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = ~RES_MAX;

  // Result buffer and the fixed distance from input accept to buffer write.
  localparam int FIFO_AW    = 3;
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;
  localparam int PIPE_LAT   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_I,
    REG_SIZE_J,
    REG_SIZE_K,
    REG_COEF_X,
    REG_COEF_Y,
    REG_COEF_Z
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]   si;
    logic [DIM_W-1:0]   sj;
    logic [DIM_W-1:0]   sk;
    logic [PLANE_W-1:0] plane;
    logic [COEF_W-1:0]  coef_x;
    logic [COEF_W-1:0]  coef_y;
    logic [COEF_W-1:0]  coef_z;
  } cfg_t;

  typedef struct packed {
    logic             inner;
    logic             last;
    logic [POS_W-1:0] pi;
    logic [POS_W-1:0] pj;
    logic [POS_W-1:0] pk;
  } meta_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] cur;
    logic [VALUE_WIDTH-1:0] c;
    logic [VALUE_WIDTH-1:0] xm;
    logic [VALUE_WIDTH-1:0] ym;
    logic [VALUE_WIDTH-1:0] yp;
    logic [VALUE_WIDTH-1:0] zm;
    logic [VALUE_WIDTH-1:0] zp;
    logic [VALUE_WIDTH-1:0] o;
  } taps_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
    logic [POS_W-1:0]       pi;
    logic [POS_W-1:0]       pj;
    logic [POS_W-1:0]       pk;
  } res_t;

endpackage

// ===== hw/rtl/wes_if.sv =====
// Valid/ready channel interfaces for the grid input, the result output and
// the configuration write port. Depends on wes_pkg.
interface wes_in_if import wes_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] current_value;
  logic signed [VALUE_WIDTH-1:0] older_value;

  modport source (output valid, output current_value, output older_value, input ready);
  modport sink (input valid, input current_value, input older_value, output ready);
endinterface

interface wes_out_if import wes_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] new_value;
  logic [POS_W-1:0]              pos_i;
  logic [POS_W-1:0]              pos_j;
  logic [POS_W-1:0]              pos_k;
  logic                          last_node;

  modport source (output valid, output new_value, output pos_i, output pos_j,
                  output pos_k, output last_node, input ready);
  modport sink (input valid, input new_value, input pos_i, input pos_j,
                input pos_k, input last_node, output ready);
endinterface

interface wes_cfg_if import wes_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/wes_config.sv =====
// Configuration registers: clamped grid sizes and coefficients, plus the derived plane size.
// Depends on wes_pkg and wes_cfg_if.
module wes_config import wes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wes_cfg_if.sink   cfg_ch,
  output cfg_t      cfg,
  output logic      restart
);

  function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw);
    logic [DIM_W-1:0] v;
    v = DIM_W'(raw);
    if (v < DIM_W'(MIN_DIM)) begin
      return DIM_W'(MIN_DIM);
    end
    if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  logic [DIM_W-1:0]   size_i;
  logic [DIM_W-1:0]   size_j;
  logic [DIM_W-1:0]   size_k;
  logic [COEF_W-1:0]  coef_x;
  logic [COEF_W-1:0]  coef_y;
  logic [COEF_W-1:0]  coef_z;
  logic [2*DIM_W-1:0] plane_full;
  logic               wr;

  assign cfg_ch.ready = !rst;
  assign wr           = cfg_ch.valid && cfg_ch.ready;

  // Sizes are held already clamped, so every use sees a legal grid.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_i <= clamp_size(SIZE_W'(RESET_DIM));
      size_j <= clamp_size(SIZE_W'(RESET_DIM));
      size_k <= clamp_size(SIZE_W'(RESET_DIM));
      coef_x <= '0;
      coef_y <= '0;
      coef_z <= '0;
    end else if (wr) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_SIZE_I: size_i <= clamp_size(cfg_ch.data[SIZE_W-1:0]);
        REG_SIZE_J: size_j <= clamp_size(cfg_ch.data[SIZE_W-1:0]);
        REG_SIZE_K: size_k <= clamp_size(cfg_ch.data[SIZE_W-1:0]);
        REG_COEF_X: coef_x <= cfg_ch.data[COEF_W-1:0];
        REG_COEF_Y: coef_y <= cfg_ch.data[COEF_W-1:0];
        REG_COEF_Z: coef_z <= cfg_ch.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Any size write starts the scan again at the grid origin.
  always_comb begin
    restart = 1'b0;
    if (wr) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_SIZE_I, REG_SIZE_J, REG_SIZE_K: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  assign plane_full = size_j * size_k;

  always_comb begin
    cfg.si     = size_i;
    cfg.sj     = size_j;
    cfg.sk     = size_k;
    cfg.plane  = plane_full[PLANE_W-1:0];
    cfg.coef_x = coef_x;
    cfg.coef_y = coef_y;
    cfg.coef_z = coef_z;
  end

endmodule

// ===== hw/rtl/wes_scan.sv =====
// Scan position tracking: raster indices of the incoming word, inner-node
// test, coordinates of the node whose stencil completes, and store pointer.
// Depends on wes_pkg.
module wes_scan import wes_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              restart,
  input  cfg_t              cfg,
  output meta_t             meta,
  output logic [ADDR_W-1:0] wp
);

  logic [DIM_W-1:0] idx_i, idx_j, idx_k;
  logic [DIM_W-1:0] idx_i_next, idx_j_next, idx_k_next;
  logic [DIM_W-1:0] ci;
  logic             k_end, j_end, i_end;

  assign k_end = (idx_k == cfg.sk - DIM_W'(1));
  assign j_end = (idx_j == cfg.sj - DIM_W'(1));
  assign i_end = (idx_i == cfg.si - DIM_W'(1));

  always_comb begin
    idx_i_next = idx_i;
    idx_j_next = idx_j;
    idx_k_next = idx_k;
    if (accept) begin
      if (k_end) begin
        idx_k_next = '0;
        if (j_end) begin
          idx_j_next = '0;
          idx_i_next = i_end ? '0 : idx_i + DIM_W'(1);
        end else begin
          idx_j_next = idx_j + DIM_W'(1);
        end
      end else begin
        idx_k_next = idx_k + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      idx_i <= '0;
      idx_j <= '0;
      idx_k <= '0;
    end else begin
      idx_i <= idx_i_next;
      idx_j <= idx_j_next;
      idx_k <= idx_k_next;
    end
  end

  // The store pointer counts words and ignores restarts: tap distances are in
  // words, and a scan only ever looks back at words of its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (accept) begin
      wp <= wp + ADDR_W'(1);
    end
  end

  // The word at (i, j, k) completes the stencil centred one plane back.
  assign ci = idx_i - DIM_W'(1);

  always_comb begin
    meta.inner = (idx_i >= DIM_W'(2)) &&
                 (idx_j >= DIM_W'(1)) && (idx_j <= cfg.sj - DIM_W'(2)) &&
                 (idx_k >= DIM_W'(1)) && (idx_k <= cfg.sk - DIM_W'(2));
    meta.last  = (ci == cfg.si - DIM_W'(2)) && (idx_j == cfg.sj - DIM_W'(2)) &&
                 (idx_k == cfg.sk - DIM_W'(2));
    meta.pi    = ci[POS_W-1:0];
    meta.pj    = idx_j[POS_W-1:0];
    meta.pk    = idx_k[POS_W-1:0];
  end

  a_restart_origin: assert property (@(posedge clk) disable iff (rst)
    restart |=> (idx_i == '0 && idx_j == '0 && idx_k == '0))
    else $error("scan did not return to the origin after a size write");

endmodule

// ===== hw/rtl/wes_window.sv =====
// Stencil window: two one-plane delay stores in synchronous RAM plus short
// shift registers, presenting all seven taps of one node together.
// Depends on wes_pkg.
module wes_window import wes_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [VALUE_WIDTH-1:0] cur,
  input  logic [VALUE_WIDTH-1:0] old,
  input  logic [ADDR_W-1:0]      wp,
  input  meta_t                  meta,
  input  cfg_t                   cfg,
  output taps_t                  taps,
  output meta_t                  node_meta,
  output logic                   node_valid
);

  // Input store holds {older, current} per word; the centre store holds the
  // centre value of each word's stencil, giving the far y and x taps.
  logic [2*VALUE_WIDTH-1:0] win_mem [DEPTH];
  logic [VALUE_WIDTH-1:0]   ctr_mem [DEPTH];

  logic [ADDR_W-1:0]        back0, addr_zp, addr_yp, addr_ym, addr_xm;
  logic [2*VALUE_WIDTH-1:0] rd_a;
  logic [VALUE_WIDTH-1:0]   rd_b;
  logic [VALUE_WIDTH-1:0]   rd_ym, rd_xm;

  logic                   s1_item;
  logic [VALUE_WIDTH-1:0] s1_cur;
  meta_t                  s1_meta;
  logic [ADDR_W-1:0]      s1_wp;

  logic [VALUE_WIDTH-1:0] zq, cq, oq;

  logic                   s2_valid;
  logic [VALUE_WIDTH-1:0] s2_cur, s2_c, s2_zm, s2_zp, s2_yp, s2_o;
  meta_t                  s2_meta;

  // Read one word short of a plane back (z+ neighbour, older value a word
  // early) and a plane less one row back (y+ neighbour).
  assign back0   = wp - ADDR_W'(cfg.plane);
  assign addr_zp = back0 + ADDR_W'(1);
  assign addr_yp = back0 + ADDR_W'(cfg.sk);

  always_ff @(posedge clk) begin
    if (accept) begin
      win_mem[wp] <= {old, cur};
      rd_a        <= win_mem[addr_zp];
      rd_b        <= win_mem[addr_yp][VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_item <= 1'b0;
    end else begin
      s1_item <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur  <= cur;
      s1_meta <= meta;
      s1_wp   <= wp;
    end
  end

  // The centre store is written with this word's centre while the same
  // cycle reads one row and one plane back. A plane of exactly the store
  // depth reads the entry being written, and read-first gives the old word.
  assign addr_ym = s1_wp - ADDR_W'(cfg.sk);
  assign addr_xm = s1_wp - ADDR_W'(cfg.plane);

  // zq, cq and oq shift once per word, so the centre and z- tap are the z+
  // tap of one and two words earlier, and the older value lags by one word.
  always_ff @(posedge clk) begin
    if (s1_item) begin
      zq             <= rd_a[VALUE_WIDTH-1:0];
      cq             <= zq;
      oq             <= rd_a[2*VALUE_WIDTH-1:VALUE_WIDTH];
      ctr_mem[s1_wp] <= zq;
      rd_ym          <= ctr_mem[addr_ym];
      rd_xm          <= ctr_mem[addr_xm];
      s2_cur         <= s1_cur;
      s2_c           <= zq;
      s2_zm          <= cq;
      s2_zp          <= rd_a[VALUE_WIDTH-1:0];
      s2_yp          <= rd_b;
      s2_o           <= oq;
      s2_meta        <= s1_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_item && s1_meta.inner;
    end
  end

  always_comb begin
    taps.cur = s2_cur;
    taps.c   = s2_c;
    taps.xm  = rd_xm;
    taps.ym  = rd_ym;
    taps.yp  = s2_yp;
    taps.zm  = s2_zm;
    taps.zp  = s2_zp;
    taps.o   = s2_o;
  end

  assign node_meta  = s2_meta;
  assign node_valid = s2_valid;

endmodule

// ===== hw/rtl/wes_datapath.sv =====
// Stencil arithmetic: second differences, coefficient products, sum with
// floor scaling, and saturation to the value width. Depends on wes_pkg.
module wes_datapath import wes_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  taps_t taps,
  input  meta_t node_meta,
  input  logic  node_valid,
  input  cfg_t  cfg,
  output res_t  res,
  output logic  res_valid
);

  logic signed [DIFF_W-1:0] e_cur, e_c, e_xm, e_ym, e_yp, e_zm, e_zp, e_o;

  logic                     v1, v2, v3;
  meta_t                    m1, m2, m3;
  logic signed [DIFF_W-1:0] dxx, dyy, dzz, base1, base2, base3;
  logic signed [PROD_W-1:0] px, py, pz;
  logic signed [SUM_W-1:0]  sum3, scaled;
  logic signed [RES_W-1:0]  full;
  logic signed [RES_W-1:0]  sat;

  assign e_cur = DIFF_W'($signed(taps.cur));
  assign e_c   = DIFF_W'($signed(taps.c));
  assign e_xm  = DIFF_W'($signed(taps.xm));
  assign e_ym  = DIFF_W'($signed(taps.ym));
  assign e_yp  = DIFF_W'($signed(taps.yp));
  assign e_zm  = DIFF_W'($signed(taps.zm));
  assign e_zp  = DIFF_W'($signed(taps.zp));
  assign e_o   = DIFF_W'($signed(taps.o));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= node_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    m1    <= node_meta;
    dxx   <= e_xm + e_cur - (e_c <<< 1);
    dyy   <= e_ym + e_yp - (e_c <<< 1);
    dzz   <= e_zm + e_zp - (e_c <<< 1);
    base1 <= (e_c <<< 1) - e_o;

    m2    <= m1;
    px    <= dxx * $signed({1'b0, cfg.coef_x});
    py    <= dyy * $signed({1'b0, cfg.coef_y});
    pz    <= dzz * $signed({1'b0, cfg.coef_z});
    base2 <= base1;

    m3    <= m2;
    sum3  <= SUM_W'(px) + SUM_W'(py) + SUM_W'(pz);
    base3 <= base2;
  end

  // The arithmetic shift floors the weighted sum towards minus infinity.
  assign scaled = sum3 >>> FRAC_BITS;
  assign full   = RES_W'(scaled) + RES_W'(base3);

  always_comb begin
    priority if (full > RES_MAX) begin
      sat = RES_MAX;
    end else if (full < RES_MIN) begin
      sat = RES_MIN;
    end else begin
      sat = full;
    end
  end

  always_comb begin
    res.value = sat[VALUE_WIDTH-1:0];
    res.last  = m3.last;
    res.pi    = m3.pi;
    res.pj    = m3.pj;
    res.pk    = m3.pk;
  end

  assign res_valid = v3;

endmodule

// ===== hw/rtl/wes_out_fifo.sv =====
// Result buffer with credit accounting: a result slot is reserved when an
// inner-node word is taken, so the pipeline never has to stall.
// Depends on wes_pkg and wes_out_if.
module wes_out_fifo import wes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       reserve,
  input  logic       wr_valid,
  input  res_t       wr_data,
  wes_out_if.source  result_ch,
  output logic       space
);

  res_t               buf_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   fill, fill_next;
  logic [FIFO_AW:0]   pending, pending_next;
  logic               pop;

  assign pop = result_ch.valid && result_ch.ready;

  always_comb begin
    fill_next    = fill;
    pending_next = pending;
    if (wr_valid) begin
      fill_next = fill_next + (FIFO_AW+1)'(1);
    end
    if (pop) begin
      fill_next    = fill_next - (FIFO_AW+1)'(1);
      pending_next = pending_next - (FIFO_AW+1)'(1);
    end
    if (reserve) begin
      pending_next = pending_next + (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      pending <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill    <= fill_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      buf_mem[wr_ptr] <= wr_data;
    end
  end

  assign result_ch.valid     = (fill != '0);
  assign result_ch.new_value = $signed(buf_mem[rd_ptr].value);
  assign result_ch.pos_i     = buf_mem[rd_ptr].pi;
  assign result_ch.pos_j     = buf_mem[rd_ptr].pj;
  assign result_ch.pos_k     = buf_mem[rd_ptr].pk;
  assign result_ch.last_node = buf_mem[rd_ptr].last;

  // Words still in the pipeline plus those buffered never exceed the depth.
  assign space = (pending < (FIFO_AW+1)'(FIFO_DEPTH));

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("more results owed than the buffer can hold");

  a_fill_covered: assert property (@(posedge clk) disable iff (rst)
    fill <= pending)
    else $error("buffered results exceed reserved slots");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> (fill != (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("result written into a full buffer");

endmodule

// ===== hw/rtl/wave_equation_stencil_update_top.sv =====
// Top level of the streamed 3-D wave equation 7-point stencil update.
// Depends on wes_pkg, the channel interfaces and all wes_* modules.
//
// Usage: grid points enter on grid_ch in raster order (k fastest, i slowest),
// each word carrying the previous-layer and older-layer values. For every
// inner node one word leaves on result_ch with the new value (Q16.16,
// saturated), its coordinates and a flag on the final inner node; boundary
// nodes give no result. The node (i-1, j, k) is completed by input (i, j, k).
// Registers are written on cfg_ch: sizes (clamped to 3..64) and the three
// coefficients tau^2/h^2; a size write restarts the scan at the origin.
// Throughput is one input word per cycle while grid_ch.ready is high, set by
// the single write and two read ports of each delay store. A result word is
// presented after the input word that completes it is taken and passes the
// store read, centre store read, difference, multiply, sum and saturate.
// Reset sets all sizes to 64, the coefficients to zero and the scan to the
// origin; the delay stores are not cleared, as a scan only reads entries it
// has written itself. Up to eight results may be owed at once: when the
// receiver stalls they collect in the output buffer, and grid_ch.ready falls
// only once eight are in flight or waiting.
module wave_equation_stencil_update_top import wes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wes_in_if.sink    grid_ch,
  wes_out_if.source result_ch,
  wes_cfg_if.sink   cfg_ch
);

  cfg_t              cfg;
  logic              restart;
  meta_t             scan_meta;
  logic [ADDR_W-1:0] wp;
  logic              accept;
  taps_t             taps;
  meta_t             win_meta;
  logic              win_valid;
  res_t              res;
  logic              res_valid;
  logic              space;

  assign grid_ch.ready = space && !rst;
  assign accept        = grid_ch.valid && grid_ch.ready;

  wes_config u_config (
    .clk     (clk),
    .rst     (rst),
    .cfg_ch  (cfg_ch),
    .cfg     (cfg),
    .restart (restart)
  );

  wes_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .restart (restart),
    .cfg     (cfg),
    .meta    (scan_meta),
    .wp      (wp)
  );

  wes_window u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cur        (grid_ch.current_value),
    .old        (grid_ch.older_value),
    .wp         (wp),
    .meta       (scan_meta),
    .cfg        (cfg),
    .taps       (taps),
    .node_meta  (win_meta),
    .node_valid (win_valid)
  );

  wes_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .taps       (taps),
    .node_meta  (win_meta),
    .node_valid (win_valid),
    .cfg        (cfg),
    .res        (res),
    .res_valid  (res_valid)
  );

  wes_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .reserve   (accept && scan_meta.inner),
    .wr_valid  (res_valid),
    .wr_data   (res),
    .result_ch (result_ch),
    .space     (space)
  );

  // Every inner-node word reaches the result buffer after a fixed latency.
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && scan_meta.inner) |-> ##PIPE_LAT res_valid)
    else $error("inner-node word did not produce a result on time");

endmodule
